// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL. Both sample on clock and are off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: property failed");
`define ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/core/prf_pkg.sv =====
package prf_pkg;

   localparam int MAX_LEN = 1024;

   // Field widths on the stream ports
   localparam int CHAR_W     = 8;
   localparam int CENTER_W   = 12;
   localparam int RADIUS_W   = 10;
   localparam int START_W    = 10;
   localparam int LENGTH_W   = 11;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - (RADIUS_W + START_W + LENGTH_W + STATUS_W);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_RADIUS = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_MIRROR_RD,
      S_MIRROR,
      S_CMP,
      S_TAIL,
      S_READ
   } state_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== rtl/core/prf_ram.sv =====
module prf_ram #(
   parameter int WIDTH    = prf_pkg::CHAR_W,
   parameter int DEPTH    = prf_pkg::MAX_LEN,
   parameter int RD_PORTS = 1,
   localparam int AW      = prf_pkg::addr_width(DEPTH)
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic [RD_PORTS-1:0]               rd_en,
   input  logic [RD_PORTS-1:0][AW-1:0]       rd_addr,
   output logic [RD_PORTS-1:0][WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0]                 mem_ff [DEPTH];
   logic [RD_PORTS-1:0][WIDTH-1:0]   rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next enabled read
   always_ff @(posedge clock) begin
      for (int i = 0; i < RD_PORTS; i++) begin
         if (rd_en[i]) begin
            rd_data_ff[i] <= mem_ff[rd_addr[i]];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/palindrome_radii_finder.sv =====
// Longest-palindrome finder over a loaded byte string.
// Request channel (req_*): tuser selects load (0) or radius read (1). A load puts
// one character at the end of the string; tlast on a load closes the string and
// starts the radius pass. A load after a closed string starts a new one; characters
// past MAX_LEN are dropped and flagged in the report.
// Response channel (rsp_*): tuser 0 is the report (longest radius, start, length),
// tuser 1 answers a read, from the radius store's read register via S_READ into
// the response register. The closing load runs a pass over all 2N+1 centers; each
// center reads its mirror radius (S_MIRROR_RD, S_MIRROR), then compares one
// character pair per S_CMP step on both read ports of the text store, one compare
// per cycle, until the palindrome stops growing or reaches the string's end.
// Requests are taken only while the block is idle and the response register is
// free or draining; a stalled response holds, and nothing further is taken until
// it leaves. Reset (synchronous) empties the string and drops any pending
// response; the text and radius stores are not cleared, and a read is only
// answered from centers of a closed string.
module palindrome_radii_finder #(
   parameter int MAX_LEN = prf_pkg::MAX_LEN
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_byte [7:0], center_index [19:8]
   input  logic [prf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // radius [9:0], longest_start [19:10], longest_length [30:20], status [32:31]
   output logic [prf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // kind
   output logic                            rsp_tuser
);

`include "assert_macros.svh"

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int CW = LW + 1;
   localparam int AW = prf_pkg::addr_width(MAX_LEN);
   localparam int RW = $clog2(MAX_LEN / 2 + 2);
   localparam int RAD_DEPTH = 2 * MAX_LEN + 1;
   localparam int XW = (CW > prf_pkg::CENTER_W) ? CW : prf_pkg::CENTER_W;

   prf_pkg::state_type state_ff, state_in;

   logic [LW-1:0]  len_ff, len_in;
   logic           done_ff, done_in;
   logic           ovf_ff, ovf_in;
   logic [CW-1:0]  p_ff, p_in;
   logic [RW-1:0]  r_ff, r_in;
   logic [CW-1:0]  span_c_ff, span_c_in;
   logic [CW-1:0]  span_rb_ff, span_rb_in;
   logic [RW-1:0]  best_r_ff, best_r_in;
   logic [CW-1:0]  best_c_ff, best_c_in;
   logic           rd_err_ff, rd_err_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_kind_ff, rsp_kind_in;
   logic [prf_pkg::RADIUS_W-1:0]    rsp_radius_ff, rsp_radius_in;
   logic [prf_pkg::START_W-1:0]     rsp_start_ff, rsp_start_in;
   logic [prf_pkg::LENGTH_W-1:0]    rsp_length_ff, rsp_length_in;
   logic [prf_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // memories
   logic                     txt_wr_en;
   logic [AW-1:0]            txt_wr_addr;
   logic [7:0]               txt_wr_data;
   logic [1:0]               txt_rd_en;
   logic [1:0][AW-1:0]       txt_rd_addr;
   logic [1:0][7:0]          txt_rd_data;

   logic                     rad_wr_en;
   logic [CW-1:0]            rad_wr_addr;
   logic [RW-1:0]            rad_wr_data;
   logic [0:0]               rad_rd_en;
   logic [0:0][CW-1:0]       rad_rd_addr;
   logic [0:0][RW-1:0]       rad_rd_data;

   // request fields
   logic                              req_cmd;
   logic [prf_pkg::CHAR_W-1:0]        req_char;
   logic [prf_pkg::CENTER_W-1:0]      req_center;
   logic                              req_fire;
   logic                              out_free;

   assign req_cmd    = req_tuser;
   assign req_char   = req_tdata[prf_pkg::CHAR_W-1:0];
   assign req_center = req_tdata[prf_pkg::CHAR_W +: prf_pkg::CENTER_W];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == prf_pkg::S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   // datapath terms
   logic [CW-1:0]  two_n;
   logic [LW-1:0]  half;
   logic [CW:0]    two_c;
   logic           mir_ok;
   logic [CW:0]    mir_idx;
   logic [CW-1:0]  lim;
   logic [CW-1:0]  mr_ext;
   logic [RW-1:0]  r_mirror;
   logic [RW-1:0]  r_sel;
   logic [RW-1:0]  r_fin;
   logic [LW:0]    r_x;
   logic [LW:0]    half_x;
   logic [LW:0]    hi_x;
   logic [LW:0]    lo_x;
   logic           probe_ok;
   logic           go_probe;
   logic           eq;
   logic [CW:0]    span_reach;
   logic           p_more;
   logic [XW-1:0]  center_x;
   logic           rng_err;
   logic [LW-1:0]  len_base;
   logic           room;
   logic [31:0]    rep_rad32;
   logic [31:0]    rep_start32;
   logic [31:0]    rep_len32;
   logic [31:0]    rd_rad32;

   assign two_n   = {len_ff, 1'b0};
   assign half    = p_ff[CW-1:1];

   // mirror of p about the spanning center, and the room left inside its span
   assign two_c   = {span_c_ff, 1'b0};
   assign mir_ok  = (span_rb_ff > p_ff) && (two_c >= {1'b0, p_ff});
   assign mir_idx = two_c - {1'b0, p_ff};
   assign lim     = (span_rb_ff - p_ff) >> 1;
   assign mr_ext  = CW'(rad_rd_data[0]);
   assign r_mirror = !mir_ok       ? '0 :
                     (mr_ext < lim) ? rad_rd_data[0] : RW'(lim);

   assign eq       = (txt_rd_data[0] == txt_rd_data[1]);
   assign go_probe = (state_ff == prf_pkg::S_MIRROR) || ((state_ff == prf_pkg::S_CMP) && eq);
   assign r_sel    = (state_ff == prf_pkg::S_MIRROR) ? r_mirror : r_ff + RW'(1);
   assign r_fin    = go_probe ? r_sel : r_ff;

   // shared probe unit: next character pair around center p at radius r_sel
   assign r_x      = (LW + 1)'(r_sel);
   assign half_x   = {1'b0, half};
   assign hi_x     = half_x + r_x + (LW + 1)'(p_ff[0]);
   assign lo_x     = half_x - r_x - (LW + 1)'(1);
   assign probe_ok = (r_x < half_x) && (hi_x < {1'b0, len_ff});

   assign span_reach = (CW + 1)'(p_ff) + ((CW + 1)'(r_fin) << 1);
   assign p_more     = ((CW + 1)'(p_ff) + (CW + 1)'(1)) < (CW + 1)'(two_n);

   assign center_x = XW'(req_center);
   assign rng_err  = !done_ff || (center_x > XW'(two_n));

   assign len_base = done_ff ? '0 : len_ff;
   assign room     = len_base < LW'(MAX_LEN);

   assign rep_rad32   = 32'(best_r_ff);
   assign rep_start32 = 32'(best_c_ff[CW-1:1]) - 32'(best_r_ff);
   assign rep_len32   = 32'({best_r_ff, 1'b0}) + 32'(best_c_ff[0]);
   assign rd_rad32    = rd_err_ff ? 32'd0 : 32'(rad_rd_data[0]);

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      done_in       = done_ff;
      ovf_in        = ovf_ff;
      p_in          = p_ff;
      r_in          = r_ff;
      span_c_in     = span_c_ff;
      span_rb_in    = span_rb_ff;
      best_r_in     = best_r_ff;
      best_c_in     = best_c_ff;
      rd_err_in     = rd_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_radius_in = rsp_radius_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;

      txt_wr_en      = 1'b0;
      txt_wr_addr    = AW'(len_base);
      txt_wr_data    = req_char;
      txt_rd_en      = 2'b00;
      txt_rd_addr[0] = AW'(lo_x);
      txt_rd_addr[1] = AW'(hi_x);

      rad_wr_en      = 1'b0;
      rad_wr_addr    = p_ff;
      rad_wr_data    = r_fin;
      rad_rd_en      = 1'b0;
      rad_rd_addr[0] = mir_idx[CW-1:0];

      unique case (state_ff) inside
         prf_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_cmd == prf_pkg::CMD_READ) begin
                  rad_rd_en      = 1'b1;
                  rad_rd_addr[0] = center_x[CW-1:0];
                  rd_err_in      = rng_err;
                  state_in       = prf_pkg::S_READ;
               end else begin
                  done_in = 1'b0;
                  ovf_in  = done_ff ? 1'b0 : ovf_ff;
                  len_in  = len_base;
                  if (room) begin
                     txt_wr_en = 1'b1;
                     len_in    = len_base + LW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_tlast) begin
                     state_in = prf_pkg::S_START;
                  end
               end
            end
         end
         prf_pkg::S_START: begin
            rad_wr_en   = 1'b1;
            rad_wr_addr = '0;
            rad_wr_data = '0;
            p_in        = CW'(1);
            span_c_in   = '0;
            span_rb_in  = '0;
            best_r_in   = '0;
            best_c_in   = '0;
            state_in    = prf_pkg::S_MIRROR_RD;
         end
         prf_pkg::S_MIRROR_RD: begin
            rad_rd_en = 1'b1;
            state_in  = prf_pkg::S_MIRROR;
         end
         prf_pkg::S_MIRROR, prf_pkg::S_CMP: begin
            if (go_probe && probe_ok) begin
               txt_rd_en = 2'b11;
               r_in      = r_sel;
               state_in  = prf_pkg::S_CMP;
            end else begin
               rad_wr_en = 1'b1;
               if (span_reach > (CW + 1)'(span_rb_ff)) begin
                  span_c_in  = p_ff;
                  span_rb_in = span_reach[CW-1:0];
               end
               // first strictly largest wins
               if (r_fin > best_r_ff) begin
                  best_r_in = r_fin;
                  best_c_in = p_ff;
               end
               if (p_more) begin
                  p_in     = p_ff + CW'(1);
                  state_in = prf_pkg::S_MIRROR_RD;
               end else begin
                  state_in = prf_pkg::S_TAIL;
               end
            end
         end
         prf_pkg::S_TAIL: begin
            rad_wr_en   = 1'b1;
            rad_wr_addr = two_n;
            rad_wr_data = '0;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = prf_pkg::KIND_REPORT;
               rsp_radius_in = rep_rad32[prf_pkg::RADIUS_W-1:0];
               rsp_start_in  = rep_start32[prf_pkg::START_W-1:0];
               rsp_length_in = rep_len32[prf_pkg::LENGTH_W-1:0];
               rsp_status_in = ovf_ff ? prf_pkg::STATUS_OVERFLOW : prf_pkg::STATUS_OK;
               done_in       = 1'b1;
               state_in      = prf_pkg::S_IDLE;
            end
         end
         prf_pkg::S_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = prf_pkg::KIND_RADIUS;
               rsp_radius_in = rd_rad32[prf_pkg::RADIUS_W-1:0];
               rsp_start_in  = '0;
               rsp_length_in = '0;
               rsp_status_in = rd_err_ff ? prf_pkg::STATUS_RANGE : prf_pkg::STATUS_OK;
               state_in      = prf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = prf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prf_pkg::S_IDLE;
         len_ff       <= '0;
         done_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         span_c_ff    <= '0;
         span_rb_ff   <= '0;
         best_r_ff    <= '0;
         best_c_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         span_c_ff    <= span_c_in;
         span_rb_ff   <= span_rb_in;
         best_r_ff    <= best_r_in;
         best_c_ff    <= best_c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      r_ff          <= r_in;
      rd_err_ff     <= rd_err_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_radius_ff <= rsp_radius_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   prf_ram #(
      .WIDTH    (8),
      .DEPTH    (MAX_LEN),
      .RD_PORTS (2)
   ) u_text (
      .clock   (clock),
      .wr_en   (txt_wr_en),
      .wr_addr (txt_wr_addr),
      .wr_data (txt_wr_data),
      .rd_en   (txt_rd_en),
      .rd_addr (txt_rd_addr),
      .rd_data (txt_rd_data)
   );

   prf_ram #(
      .WIDTH    (RW),
      .DEPTH    (RAD_DEPTH),
      .RD_PORTS (1)
   ) u_radius (
      .clock   (clock),
      .wr_en   (rad_wr_en),
      .wr_addr (rad_wr_addr),
      .wr_data (rad_wr_data),
      .rd_en   (rad_rd_en),
      .rd_addr (rad_rd_addr),
      .rd_data (rad_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{prf_pkg::RSP_PAD_W{1'b0}}, rsp_status_ff, rsp_length_ff,
                        rsp_start_ff, rsp_radius_ff};

   `ASSERT_CLK(a_rad_write_bound, rad_wr_en |-> (rad_wr_addr <= two_n))
   `ASSERT_CLK(a_cmp_radius_bound, (state_ff == prf_pkg::S_CMP) |-> (LW'(r_ff) < half))
   `ASSERT_NEVER(a_report_range,
      rsp_valid_ff && (rsp_kind_ff == prf_pkg::KIND_REPORT) &&
      (rsp_status_ff == prf_pkg::STATUS_RANGE))
   `ASSERT_CLK(a_done_with_report,
      $rose(done_ff) |-> (rsp_valid_ff && (rsp_kind_ff == prf_pkg::KIND_REPORT)))

endmodule

// ===== sim/palindrome_radii_finder_tb.sv =====
`timescale 1ns / 1ps

module palindrome_radii_finder_tb;
   import prf_pkg::*;

   typedef struct packed {
      logic                kind;
      logic [RADIUS_W-1:0] radius;
      logic [START_W-1:0]  start;
      logic [LENGTH_W-1:0] length;
      logic [STATUS_W-1:0] status;
   } answer_type;

   typedef logic [CHAR_W-1:0] text_type [$];

   class radii_scoreboard;
      answer_type       pending_answers [$];
      logic [CHAR_W-1:0] text_mem [MAX_LEN];
      int unsigned      radius_mem [2 * MAX_LEN + 1];
      int unsigned      text_len = 0;
      int unsigned      span = 0;
      int unsigned      best_r = 0;
      int unsigned      best_c = 0;
      bit               done = 0;
      bit               ovf = 0;
      int               errors = 0;
      int               n_loads = 0;
      int               n_reads = 0;
      int               n_strings = 0;
      int               n_checked = 0;

      task report(string what, int got, int want);
         $display("%0t: MISMATCH %s: got %0d, want %0d", $time, what, got, want);
         errors++;
      endtask

      // Manacher pass over all 2N+1 centers, then first strictly largest radius
      function void run_manacher();
         int unsigned n, total, p, c, rb, r, lim, mr, half, lo, hi, i;
         n = text_len;
         total = 2 * n + 1;
         span = 0;
         radius_mem[0] = 0;
         radius_mem[2 * n] = 0;
         for (p = 1; p + 1 < total; p++) begin
            c = span;
            rb = c + 2 * radius_mem[c];
            r = 0;
            if (rb > p && 2 * c >= p) begin
               lim = (rb - p) / 2;
               mr = radius_mem[2 * c - p];
               r = (mr < lim) ? mr : lim;
            end
            half = p / 2;
            while (r < half) begin
               lo = half - r;
               hi = (p % 2 == 1) ? half + r : half + r - 1;
               if (hi + 1 >= n || text_mem[lo - 1] != text_mem[hi + 1])
                  break;
               r++;
            end
            radius_mem[p] = r;
            if (2 * r + p > rb)
               span = p;
         end
         best_r = 0;
         best_c = 0;
         for (i = 0; i < total; i++) begin
            if (radius_mem[i] > best_r) begin
               best_r = radius_mem[i];
               best_c = i;
            end
         end
      endfunction

      function void note_request(logic cmd, logic [CHAR_W-1:0] ch, logic last,
                                 logic [CENTER_W-1:0] center);
         answer_type a;
         a = '0;
         if (cmd == CMD_READ) begin
            n_reads++;
            a.kind = KIND_RADIUS;
            if (!done || center > 2 * text_len)
               a.status = STATUS_RANGE;
            else begin
               a.radius = RADIUS_W'(radius_mem[center]);
               a.status = STATUS_OK;
            end
            pending_answers.push_back(a);
            return;
         end
         n_loads++;
         if (done) begin
            done = 0;
            text_len = 0;
            ovf = 0;
         end
         if (text_len < MAX_LEN) begin
            text_mem[text_len] = ch;
            text_len++;
         end else
            ovf = 1;
         if (!last)
            return;
         run_manacher();
         done = 1;
         n_strings++;
         a.kind = KIND_REPORT;
         a.radius = RADIUS_W'(best_r);
         a.start = START_W'(best_c / 2 - best_r);
         a.length = LENGTH_W'((best_c % 2 == 1) ? 2 * best_r + 1 : 2 * best_r);
         a.status = ovf ? STATUS_OVERFLOW : STATUS_OK;
         pending_answers.push_back(a);
      endfunction

      task check_result(logic kind, logic [RSP_DATA_W-1:0] data);
         answer_type got, want;
         got.kind = kind;
         got.radius = data[RADIUS_W-1:0];
         got.start = data[RADIUS_W +: START_W];
         got.length = data[RADIUS_W + START_W +: LENGTH_W];
         got.status = data[RADIUS_W + START_W + LENGTH_W +: STATUS_W];
         if (pending_answers.size() == 0) begin
            report("response with nothing pending, kind", got.kind, -1);
            return;
         end
         want = pending_answers.pop_front();
         n_checked++;
         if (got.kind != want.kind) report("kind", got.kind, want.kind);
         if (got.radius != want.radius) report("radius", got.radius, want.radius);
         if (got.start != want.start) report("longest_start", got.start, want.start);
         if (got.length != want.length) report("longest_length", got.length, want.length);
         if (got.status != want.status) report("status", got.status, want.status);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = CMD_LOAD;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   bit                    idling = 1'b0;
   radii_scoreboard       sb = new();

   always #1 clock = ~clock;

   palindrome_radii_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic cmd, input logic [CHAR_W-1:0] ch,
                               input logic last, input logic [CENTER_W-1:0] center);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tlast <= last;
      req_tdata <= {{(REQ_DATA_W - CENTER_W - CHAR_W){1'b0}}, center, ch};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, ch, last, center);
      @(negedge clock);
   endtask

   task automatic read_center(input int c);
      send_request(CMD_READ, CHAR_W'($urandom), 1'($urandom), CENTER_W'(c));
   endtask

   // noisy: slip the odd read in while the string is still loading
   task automatic load_text(input text_type txt, input bit noisy);
      int i;
      for (i = 0; i < txt.size(); i++) begin
         if (noisy && i > 0 && $urandom_range(0, 11) == 0)
            read_center($urandom_range(0, 2 * MAX_LEN));
         send_request(CMD_LOAD, txt[i], i == txt.size() - 1, CENTER_W'($urandom));
      end
   endtask

   // letters == 0 picks from the full byte range
   function automatic text_type make_text(input int len, input int letters,
                                          input bit mirrored);
      text_type t;
      int i;
      for (i = 0; i < len; i++) begin
         if (mirrored && 2 * i >= len)
            t.push_back(t[len - 1 - i]);
         else if (letters == 0)
            t.push_back(CHAR_W'($urandom_range(0, 255)));
         else
            t.push_back(CHAR_W'(8'h61 + $urandom_range(0, letters - 1)));
      end
      return t;
   endfunction

   // response side: random stall bursts, result check at the rising edge
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata);
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= 1'b1;
      end
   end

   initial begin
      int n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      read_center(0);                         // nothing loaded yet
      load_text('{8'h61}, 0);                 // single char: all radii zero
      read_center(0);
      read_center(1);
      read_center(2);
      read_center(3);
      load_text('{8'h61, 8'h62, 8'h62, 8'h61}, 0);
      read_center(4);
      send_request(CMD_LOAD, 8'h78, 1'b0, '0);
      send_request(CMD_LOAD, 8'h79, 1'b0, '0);
      send_request(CMD_LOAD, 8'h7A, 1'b0, '0);
      send_request(CMD_LOAD, 8'h79, 1'b0, '0);
      read_center(0);                         // string still open
      send_request(CMD_LOAD, 8'h71, 1'b1, '0);
      load_text('{8'h00, 8'hFF, 8'h00}, 0);
      read_center(3);
      read_center(2 * MAX_LEN);

      while (sb.n_loads + sb.n_reads < 550) begin
         if (sb.n_loads + sb.n_reads >= 470)
            idling = 1'b0;
         else
            idling = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 4)) read_center($urandom_range(0, 2 * MAX_LEN));
            1: load_text(make_text($urandom_range(1, 20), 0, 1'($urandom_range(0, 1))), 1);
            default: begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
               load_text(make_text(n, $urandom_range(1, 3), $urandom_range(0, 2) == 0), 1);
               repeat ($urandom_range(1, 6)) begin
                  if ($urandom_range(0, 5) == 0)
                     read_center($urandom_range(2 * n + 1, 2 * MAX_LEN));
                  else
                     read_center($urandom_range(0, 2 * n));
               end
            end
         endcase
      end
      req_tvalid <= 1'b0;

      while (sb.pending_answers.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d loads and %0d radius reads over %0d closed strings,",
               sb.n_loads, sb.n_reads, sb.n_strings);
      $display("with stall bursts on both sides; %0d responses compared", sb.n_checked);
      if (sb.errors == 0)
         $display("palindrome_radii_finder_tb: done, clean");
      else
         $display("palindrome_radii_finder_tb: done, errors");
      $finish;
   end

   initial begin
      #1500000;
      $display("timeout with %0d responses outstanding", sb.pending_answers.size());
      $display("palindrome_radii_finder_tb: done, errors");
      $finish;
   end

endmodule
